FILE: rtl/inverting_packbits_row_encoder_macros.svh
// Assertion helpers used by the checker file of the row encoder.
`ifndef INVERTING_PACKBITS_ROW_ENCODER_MACROS_SVH
`define INVERTING_PACKBITS_ROW_ENCODER_MACROS_SVH

// Checked at every clock edge once reset is released.
`define IPBRE_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// Checked at every clock edge, reset included.
`define IPBRE_ASSERT_ALWAYS(name, prop, msg) \
	name: assert property (@(posedge clk) prop) \
		else $error(msg);

`endif

FILE: rtl/ipbre_pkg.sv
package ipbre_pkg;

	localparam int GROUP_LIMIT_DEF = 128;
	localparam int OUT_LANES = 4;
	localparam int LANE_W = $clog2(OUT_LANES);

	typedef struct packed {
		logic [7:0] sample;
		logic       row_end;
	} src_item_t;

	typedef struct packed {
		logic [7:0]  out_byte_0;
		logic [7:0]  out_byte_1;
		logic [7:0]  out_byte_2;
		logic [7:0]  out_byte_3;
		logic [2:0]  lane_count;
		logic        row_done;
		logic [15:0] row_length;
	} enc_item_t;

	// One encoded byte on its way from the engine to the lane packer.
	typedef struct packed {
		logic [7:0]  data;
		logic        last;
		logic        row_end;
		logic [15:0] row_length;
	} byte_req_t;

endpackage

FILE: rtl/inverting_packbits_row_encoder.sv
// Inverting PackBits row encoder.
// The src channel carries one raw byte per request plus a row_end mark. Each
// byte is inverted and run-length coded; the enc channel returns the coded
// stream packed up to four bytes per request, with lane_count giving how many
// lanes are valid. The last request of a row has row_done set and carries the
// coded length of the row, saturated at 65535.
// A sample that closes no group leaves the engine idle, so plain streaming runs
// at one sample per cycle. A sample that closes groups holds src_stall high
// while its n coded bytes are sent, one per cycle unless the packer stalls;
// the single read port of the literal memory sets that byte rate. Each request
// of such a sample enters the output register once the packer has gathered
// its lanes and the output register is free.
// Reset clears the group state, the row tally and both valid flags; the
// literal memory is not cleared, since only entries of the open group are read.
// When enc_stall is high while enc_valid is set, the output register holds its
// request and the byte stream from the engine halts; a sample whose coded bytes
// are still being sent keeps src_stall high until they drain.
module inverting_packbits_row_encoder import ipbre_pkg::*; #(
	parameter int GROUP_LIMIT = GROUP_LIMIT_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      src_valid,
	output logic      src_stall,
	input  src_item_t src_data,
	output logic      enc_valid,
	input  logic      enc_stall,
	output enc_item_t enc_data
);

	logic      req_valid;
	byte_req_t req;
	logic      req_stall;

	ipbre_engine #(
		.GROUP_LIMIT(GROUP_LIMIT)
	) u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.src_valid(src_valid),
		.src_stall(src_stall),
		.src_data (src_data),
		.req_valid(req_valid),
		.req      (req),
		.req_stall(req_stall)
	);

	ipbre_packer u_packer (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req      (req),
		.req_stall(req_stall),
		.enc_valid(enc_valid),
		.enc_stall(enc_stall),
		.enc_data (enc_data)
	);

endmodule

FILE: rtl/ipbre_engine.sv
module ipbre_engine import ipbre_pkg::*; #(
	parameter int GROUP_LIMIT = GROUP_LIMIT_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      src_valid,
	output logic      src_stall,
	input  src_item_t src_data,
	output logic      req_valid,
	output byte_req_t req,
	input  logic      req_stall
);

	localparam int LEN_W = $clog2(GROUP_LIMIT + 1);
	localparam int ADDR_W = (GROUP_LIMIT > 1) ? $clog2(GROUP_LIMIT) : 1;
	localparam int CNT_W = LEN_W + 2;
	localparam logic [LEN_W-1:0] LEN_FULL = LEN_W'(GROUP_LIMIT);
	localparam logic [LEN_W-1:0] LEN_ONE = LEN_W'(1);
	localparam logic [LEN_W-1:0] LEN_TWO = LEN_W'(2);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PRE_HDR,
		ST_PRE_BYTE,
		ST_LIT_HDR,
		ST_LIT_DATA,
		ST_POST_HDR,
		ST_POST_BYTE
	} state_t;

	function automatic logic [7:0] rep_hdr(input logic [LEN_W-1:0] n);
		return 8'(9'd257 - 9'(n));
	endfunction

	state_t            state_q;
	logic [LEN_W-1:0]  grp_len_q;
	logic              grp_rep_q;
	logic [7:0]        prev_q;
	logic [15:0]       tally_q;
	logic [7:0]        pre_hdr_q;
	logic [7:0]        pre_byte_q;
	logic [7:0]        lit_hdr_q;
	logic [LEN_W-1:0]  lit_cnt_q;
	logic              post_vld_q;
	logic [7:0]        post_hdr_q;
	logic [7:0]        post_byte_q;
	logic              row_end_q;
	logic [15:0]       row_len_q;
	logic              defer_q;
	logic [7:0]        byte_q;
	logic [ADDR_W-1:0] idx_q;

	logic [7:0]        lit_mem_q [GROUP_LIMIT];
	logic [7:0]        lit_rd_q;

	logic              accept;
	logic              take;
	logic              done;
	logic              lit_end;
	logic [7:0]        b;
	logic              full;
	logic [LEN_W-1:0]  n_len;
	logic              n_rep;
	logic              pre_v;
	logic [7:0]        pre_h;
	logic              lit_v;
	logic [7:0]        lit_h;
	logic [LEN_W-1:0]  lit_c;
	logic              post_v;
	logic [7:0]        post_h;
	logic              wr_v;
	logic [ADDR_W-1:0] wr_a;
	logic              defer;
	logic [CNT_W-1:0]  step_cnt;
	logic [16:0]       tally_sum;
	logic [15:0]       tally_sat;
	logic              mem_we;
	logic [ADDR_W-1:0] mem_wa;
	logic [7:0]        mem_wd;
	logic [ADDR_W-1:0] rd_addr;

	assign src_stall = (state_q != ST_IDLE);
	assign req_valid = (state_q != ST_IDLE);
	assign accept = src_valid && (state_q == ST_IDLE);
	assign take = req_valid && !req_stall;
	assign done = take && req.last;
	assign lit_end = ((LEN_W'(idx_q) + LEN_ONE) == lit_cnt_q);

	// Decide at acceptance which groups close and what the new group is.
	always_comb begin
		b = ~src_data.sample;
		full = (grp_len_q == LEN_FULL);
		n_len = grp_len_q;
		n_rep = grp_rep_q;
		pre_v = 1'b0;
		pre_h = rep_hdr(grp_len_q);
		lit_v = 1'b0;
		lit_h = '0;
		lit_c = '0;
		post_v = 1'b0;
		post_h = '0;
		wr_v = 1'b0;
		wr_a = '0;
		defer = 1'b0;
		if (grp_len_q == '0) begin
			n_len = LEN_ONE;
			n_rep = 1'b0;
			wr_v = 1'b1;
		end else if (b == prev_q) begin
			if (grp_rep_q) begin
				if (full) begin
					pre_v = 1'b1;
					n_len = LEN_ONE;
					n_rep = 1'b0;
					wr_v = 1'b1;
				end else begin
					n_len = grp_len_q + LEN_ONE;
				end
			end else if (grp_len_q == LEN_ONE) begin
				n_rep = 1'b1;
				n_len = LEN_TWO;
			end else begin
				// The last literal moves into the new repeat.
				lit_v = 1'b1;
				lit_c = grp_len_q - LEN_ONE;
				lit_h = 8'(grp_len_q) - 8'd2;
				n_rep = 1'b1;
				n_len = LEN_TWO;
			end
		end else if (!grp_rep_q && !full) begin
			wr_v = 1'b1;
			wr_a = ADDR_W'(grp_len_q);
			n_len = grp_len_q + LEN_ONE;
		end else begin
			if (grp_rep_q) begin
				pre_v = 1'b1;
				wr_v = 1'b1;
			end else begin
				// Entry zero is still being flushed, so its new value is written afterward.
				lit_v = 1'b1;
				lit_c = grp_len_q;
				lit_h = 8'(grp_len_q) - 8'd1;
				defer = 1'b1;
			end
			n_len = LEN_ONE;
			n_rep = 1'b0;
		end
		if (src_data.row_end) begin
			defer = 1'b0;
			if (n_rep) begin
				post_v = 1'b1;
				post_h = rep_hdr(n_len);
			end else if (n_len == LEN_ONE) begin
				post_v = 1'b1;
				post_h = 8'd0;
			end else begin
				lit_v = 1'b1;
				lit_c = n_len;
				lit_h = 8'(n_len) - 8'd1;
			end
		end
		step_cnt = (pre_v ? CNT_W'(2) : '0) + (lit_v ? (CNT_W'(lit_c) + CNT_W'(1)) : '0)
			+ (post_v ? CNT_W'(2) : '0);
		tally_sum = 17'(tally_q) + 17'(step_cnt);
		tally_sat = tally_sum[16] ? 16'hffff : tally_sum[15:0];
	end

	always_comb begin
		req.row_end = row_end_q;
		req.row_length = row_len_q;
		req.data = '0;
		req.last = 1'b0;
		case (state_q)
			ST_PRE_HDR: req.data = pre_hdr_q;
			ST_PRE_BYTE: begin
				req.data = pre_byte_q;
				req.last = !post_vld_q;
			end
			ST_LIT_HDR: req.data = lit_hdr_q;
			ST_LIT_DATA: begin
				req.data = lit_rd_q;
				req.last = lit_end && !post_vld_q;
			end
			ST_POST_HDR: req.data = post_hdr_q;
			ST_POST_BYTE: begin
				req.data = post_byte_q;
				req.last = 1'b1;
			end
			default: req.data = '0;
		endcase
	end

	// The read address holds while the packer stalls, so the data is simply read again.
	assign rd_addr = ((state_q == ST_LIT_DATA) && take && !lit_end) ? idx_q + ADDR_W'(1) : idx_q;
	assign mem_we = (accept && wr_v) || (done && defer_q);
	assign mem_wa = accept ? wr_a : '0;
	assign mem_wd = accept ? b : byte_q;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			lit_mem_q[mem_wa] <= mem_wd;
		end
		lit_rd_q <= lit_mem_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			grp_len_q <= '0;
			grp_rep_q <= 1'b0;
			prev_q <= '0;
			tally_q <= '0;
			pre_hdr_q <= '0;
			pre_byte_q <= '0;
			lit_hdr_q <= '0;
			lit_cnt_q <= '0;
			post_vld_q <= 1'b0;
			post_hdr_q <= '0;
			post_byte_q <= '0;
			row_end_q <= 1'b0;
			row_len_q <= '0;
			defer_q <= 1'b0;
			byte_q <= '0;
			idx_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (src_valid) begin
						grp_len_q <= src_data.row_end ? '0 : n_len;
						grp_rep_q <= src_data.row_end ? 1'b0 : n_rep;
						prev_q <= b;
						tally_q <= src_data.row_end ? '0 : tally_sat;
						row_len_q <= tally_sat;
						row_end_q <= src_data.row_end;
						pre_hdr_q <= pre_h;
						pre_byte_q <= prev_q;
						lit_hdr_q <= lit_h;
						lit_cnt_q <= lit_c;
						post_vld_q <= post_v;
						post_hdr_q <= post_h;
						post_byte_q <= b;
						defer_q <= defer;
						byte_q <= b;
						idx_q <= '0;
						if (pre_v) begin
							state_q <= ST_PRE_HDR;
						end else if (lit_v) begin
							state_q <= ST_LIT_HDR;
						end else if (post_v) begin
							state_q <= ST_POST_HDR;
						end
					end
				end
				ST_PRE_HDR: begin
					if (take) begin
						state_q <= ST_PRE_BYTE;
					end
				end
				ST_PRE_BYTE: begin
					if (take) begin
						state_q <= post_vld_q ? ST_POST_HDR : ST_IDLE;
					end
				end
				ST_LIT_HDR: begin
					if (take) begin
						state_q <= ST_LIT_DATA;
					end
				end
				ST_LIT_DATA: begin
					if (take) begin
						if (lit_end) begin
							state_q <= post_vld_q ? ST_POST_HDR : ST_IDLE;
						end else begin
							idx_q <= idx_q + ADDR_W'(1);
						end
					end
				end
				ST_POST_HDR: begin
					if (take) begin
						state_q <= ST_POST_BYTE;
					end
				end
				ST_POST_BYTE: begin
					if (take) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

FILE: rtl/ipbre_packer.sv
module ipbre_packer import ipbre_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	input  byte_req_t req,
	output logic      req_stall,
	output logic      enc_valid,
	input  logic      enc_stall,
	output enc_item_t enc_data
);

	logic [LANE_W-1:0] cnt_q;
	logic [7:0]        acc_q [OUT_LANES];
	logic              enc_valid_q;
	enc_item_t         enc_data_q;

	logic              take;
	logic              closing;
	logic [7:0]        lanes [OUT_LANES];
	logic              row_done;

	assign req_stall = enc_valid_q && enc_stall;
	assign take = req_valid && !req_stall;
	assign closing = (cnt_q == LANE_W'(OUT_LANES - 1)) || req.last;
	assign row_done = req.last && req.row_end;
	assign enc_valid = enc_valid_q;
	assign enc_data = enc_data_q;

	// Lanes past the incoming byte read as zero.
	always_comb begin
		for (int j = 0; j < OUT_LANES; j++) begin
			lanes[j] = '0;
			if (LANE_W'(j) == cnt_q) begin
				lanes[j] = req.data;
			end else if (LANE_W'(j) < cnt_q) begin
				lanes[j] = acc_q[j];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && !closing) begin
			acc_q[cnt_q] <= req.data;
		end
		if (take && closing) begin
			enc_data_q.out_byte_0 <= lanes[0];
			enc_data_q.out_byte_1 <= lanes[1];
			enc_data_q.out_byte_2 <= lanes[2];
			enc_data_q.out_byte_3 <= lanes[3];
			enc_data_q.lane_count <= 3'(cnt_q) + 3'd1;
			enc_data_q.row_done <= row_done;
			enc_data_q.row_length <= row_done ? req.row_length : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			enc_valid_q <= 1'b0;
		end else begin
			if (take) begin
				cnt_q <= closing ? '0 : cnt_q + LANE_W'(1);
			end
			if (take && closing) begin
				enc_valid_q <= 1'b1;
			end else if (!enc_stall) begin
				enc_valid_q <= 1'b0;
			end
		end
	end

endmodule

FILE: rtl/ipbre_checker.sv
`include "inverting_packbits_row_encoder_macros.svh"

module ipbre_checker import ipbre_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      enc_valid,
	input logic      enc_stall,
	input enc_item_t enc_data
);

	`IPBRE_ASSERT_ALWAYS(a_rst_idle, !arst_n |-> !enc_valid, "enc_valid high during reset")

	`IPBRE_ASSERT(a_enc_hold, enc_valid && enc_stall |=> enc_valid && $stable(enc_data), "stalled request changed")

	`IPBRE_ASSERT(a_lane_range, enc_valid |-> enc_data.lane_count != 3'd0 && enc_data.lane_count <= 3'(OUT_LANES), "lane_count out of range")

	`IPBRE_ASSERT(a_row_len, enc_valid && enc_data.row_done |-> enc_data.row_length >= 16'(enc_data.lane_count), "row_length below lane_count")

endmodule

bind inverting_packbits_row_encoder ipbre_checker u_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.enc_valid(enc_valid),
	.enc_stall(enc_stall),
	.enc_data (enc_data)
);
